>>> design/twp_pkg.sv
// Shared types and constants for the three-way partition unit.
// Standalone package; used by three_way_partition_unit.
package twp_pkg;

  // Default store geometry.
  localparam int DEPTH_DEF      = 256;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed beat field widths.
  localparam int OP_W    = 2;
  localparam int IDX_W   = 8;
  localparam int WORD_W  = 32;
  localparam int POS_W   = 9;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 56;

  // Operation codes carried on in_tuser.
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PART  = 2'd2
  } op_t;

endpackage

>>> design/three_way_partition_unit.sv
// Three-way partition unit: a word store with write, read and in-place
// Dutch-flag partition of a slice. Depends on twp_pkg.
//
// A beat on the input carries an operation (in_tuser) and its operands; each
// beat yields exactly one result beat. The store is a single synchronous
// memory with one write port and one registered read port. A write goes
// from the accepting cycle straight to DONE; a read passes through RDATA,
// where the registered read data is taken, and then DONE.
// A partition walks the slice with pointers i, j and kn into the store: each
// word is fetched in RD and classified in EVAL; a smaller word adds WRJ when
// the equal run is not empty, and a larger word adds RDK, SWK and WRK (the
// swap with the top of the unsorted region needs a second read and two
// writes through the single write port). An empty slice goes straight to
// DONE. One operation is in flight at a time; the result register lets
// the next beat be accepted while a result waits.
module three_way_partition_unit
  import twp_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // index[7:0], value[39:8], range_low[47:40], range_high[55:48],
  // pivot_value[87:56]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // operation[1:0]
  input  logic [OP_W-1:0]        in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // read_data[31:0], equal_begin[40:32], greater_begin[49:41], zero[55:50]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDATA,
    S_RD,
    S_EVAL,
    S_WRJ,
    S_RDK,
    S_SWK,
    S_WRK,
    S_DONE
  } state_t;

  // Input beat fields
  logic [IDX_W-1:0]  in_index;
  logic [WORD_W-1:0] in_value;
  logic [IDX_W-1:0]  in_range_low;
  logic [IDX_W-1:0]  in_range_high;
  logic [WORD_W-1:0] in_pivot;
  op_t               in_op;

  assign in_index      = in_tdata[7:0];
  assign in_value      = in_tdata[39:8];
  assign in_range_low  = in_tdata[47:40];
  assign in_range_high = in_tdata[55:48];
  assign in_pivot      = in_tdata[87:56];
  assign in_op         = op_t'(in_tuser);

  // Registers
  state_t                  state_r, state_nxt;
  logic [POS_W-1:0]        i_r, i_nxt;
  logic [POS_W-1:0]        j_r, j_nxt;
  logic [POS_W-1:0]        kn_r, kn_nxt;     // one past the top of the unsorted region
  logic [DATA_WIDTH-1:0]   pivot_r, pivot_nxt;
  logic [DATA_WIDTH-1:0]   wj_r, wj_nxt;
  logic [WORD_W-1:0]       res_rd_r, res_rd_nxt;
  logic [POS_W-1:0]        res_eq_r, res_eq_nxt;
  logic [POS_W-1:0]        res_gt_r, res_gt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;

  // Store and its ports
  logic [DATA_WIDTH-1:0]   word_store [DEPTH];
  logic [DATA_WIDTH-1:0]   rdata_r;
  logic                    mem_we;
  logic [AW-1:0]           mem_wa;
  logic [DATA_WIDTH-1:0]   mem_wd;
  logic [AW-1:0]           mem_ra;

  logic                    in_acc;
  logic [IDX_W-1:0]        idx_red;
  logic [AW-1:0]           idx_addr;
  logic [POS_W-1:0]        hi_sat;
  logic [POS_W-1:0]        kn_dec;
  logic                    out_free;
  logic                    less_than;
  logic                    greater_than;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;
  assign kn_dec     = kn_r - POS_W'(1);

  // Index wraps modulo DEPTH: restoring reduction, one shifted compare per bit
  always_comb begin
    idx_red = in_index;
    for (int s = IDX_W - 1; s >= 0; s--) begin
      if (32'(idx_red) >= (32'(DEPTH) << s)) begin
        idx_red = idx_red - IDX_W'(32'(DEPTH) << s);
      end
    end
  end
  assign idx_addr = AW'(idx_red);

  // Slice top saturates to the last entry
  always_comb begin
    if (32'(in_range_high) > 32'(DEPTH - 1)) begin
      hi_sat = POS_W'(DEPTH - 1);
    end else begin
      hi_sat = POS_W'(in_range_high);
    end
  end

  assign less_than    = $signed(rdata_r) < $signed(pivot_r);
  assign greater_than = $signed(rdata_r) > $signed(pivot_r);

  // Store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      word_store[mem_wa] <= mem_wd;
    end
    rdata_r <= word_store[mem_ra];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    kn_nxt        = kn_r;
    pivot_nxt     = pivot_r;
    wj_nxt        = wj_r;
    res_rd_nxt    = res_rd_r;
    res_eq_nxt    = res_eq_r;
    res_gt_nxt    = res_gt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = AW'(j_r);
    mem_wd        = rdata_r;
    mem_ra        = idx_addr;

    // result register drains independently
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        mem_ra = idx_addr;
        if (in_acc) begin
          res_rd_nxt = '0;
          res_eq_nxt = '0;
          res_gt_nxt = '0;
          unique case (in_op)
            OP_WRITE: begin
              mem_we    = 1'b1;
              mem_wa    = idx_addr;
              mem_wd    = DATA_WIDTH'($signed(in_value));
              state_nxt = S_DONE;
            end
            OP_READ: begin
              state_nxt = S_RDATA;
            end
            OP_PART: begin
              pivot_nxt = DATA_WIDTH'($signed(in_pivot));
              if (POS_W'(in_range_low) > hi_sat) begin
                res_eq_nxt = POS_W'(in_range_low);
                res_gt_nxt = POS_W'(in_range_low);
                state_nxt  = S_DONE;
              end else begin
                i_nxt     = POS_W'(in_range_low);
                j_nxt     = POS_W'(in_range_low);
                kn_nxt    = hi_sat + POS_W'(1);
                state_nxt = S_RD;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_RDATA: begin
        res_rd_nxt = WORD_W'($signed(rdata_r));
        state_nxt  = S_DONE;
      end

      // fetch the next unclassified word, or finish
      S_RD: begin
        mem_ra = AW'(j_r);
        if (j_r < kn_r) begin
          state_nxt = S_EVAL;
        end else begin
          res_eq_nxt = i_r;
          res_gt_nxt = kn_r;
          state_nxt  = S_DONE;
        end
      end

      // classify; words in [i, j) all equal the pivot
      S_EVAL: begin
        if (less_than) begin
          if (i_r != j_r) begin
            mem_we    = 1'b1;
            mem_wa    = AW'(i_r);
            mem_wd    = rdata_r;
            state_nxt = S_WRJ;
          end else begin
            i_nxt     = i_r + POS_W'(1);
            j_nxt     = j_r + POS_W'(1);
            state_nxt = S_RD;
          end
        end else if (greater_than) begin
          wj_nxt    = rdata_r;
          state_nxt = S_RDK;
        end else begin
          j_nxt     = j_r + POS_W'(1);
          state_nxt = S_RD;
        end
      end

      // second half of the swap with the equal run
      S_WRJ: begin
        mem_we    = 1'b1;
        mem_wa    = AW'(j_r);
        mem_wd    = pivot_r;
        i_nxt     = i_r + POS_W'(1);
        j_nxt     = j_r + POS_W'(1);
        state_nxt = S_RD;
      end

      S_RDK: begin
        mem_ra    = AW'(kn_dec);
        state_nxt = S_SWK;
      end

      S_SWK: begin
        mem_we    = 1'b1;
        mem_wa    = AW'(j_r);
        mem_wd    = rdata_r;
        state_nxt = S_WRK;
      end

      S_WRK: begin
        mem_we    = 1'b1;
        mem_wa    = AW'(kn_dec);
        mem_wd    = wj_r;
        kn_nxt    = kn_dec;
        state_nxt = S_RD;
      end

      // hand the result to the output register
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {(OUT_TDATA_W - WORD_W - 2 * POS_W)'(0),
                           res_gt_r, res_eq_r, res_rd_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    kn_r       <= kn_nxt;
    pivot_r    <= pivot_nxt;
    wj_r       <= wj_nxt;
    res_rd_r   <= res_rd_nxt;
    res_eq_r   <= res_eq_nxt;
    res_gt_r   <= res_gt_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
